### hdl/mbrot_pkg.sv
// Shared constants, register indexes and control/status types for the escape-time block.
package mbrot_pkg;

   // Fixed-point format of coordinates: signed, FRAC_BITS fraction bits.
   localparam int FRAC_BITS   = 28;
   localparam int COORD_W     = 32;
   localparam int COUNT_W     = 16;
   localparam int PIX_W       = 9;

   // Stream and register port widths.
   localparam int REQ_DATA_W  = 24;
   localparam int RSP_DATA_W  = 16;
   localparam int CSR_INDEX_W = 3;

   // Datapath widths. z stays within +/-2.0, so it needs three integer bits.
   localparam int Z_W   = FRAC_BITS + 3;
   // Scaled products: squares reach 4.0, the doubled cross term reaches 8.0.
   localparam int P_W   = FRAC_BITS + 5;
   // Pixel index times step, index taken as a non-negative signed value.
   localparam int OFF_W = COORD_W + PIX_W + 1;
   // Constant c of the pixel and the updated z before range checking.
   localparam int C_W   = OFF_W + 1;
   localparam int N_W   = C_W + 1;

   // Register indexes on the configuration port.
   localparam logic [CSR_INDEX_W-1:0] REG_MAX_ITER  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_ORIGIN_RE = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_ORIGIN_IM = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_STEP_RE   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_STEP_IM   = 3'd4;

   // Register values after reset.
   localparam logic [COUNT_W-1:0]        RESET_MAX_ITER  = 16'd1000;
   localparam logic signed [COORD_W-1:0] RESET_ORIGIN_RE = -32'sd536870912;
   localparam logic signed [COORD_W-1:0] RESET_ORIGIN_IM = 32'sd268435456;
   localparam logic signed [COORD_W-1:0] RESET_STEP_RE   = 32'sd1572864;
   localparam logic signed [COORD_W-1:0] RESET_STEP_IM   = -32'sd1572864;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;     // take the pixel and clear the products and count
      logic mul_c;       // form index times step
      logic add_c;       // add the origin to get c
      logic update;      // compute the next z and its tests
      logic first;       // the update is the first pass of this pixel
      logic hold_count;  // the pending square test escaped: keep the count
      logic square;      // multiply the stored z
      logic emit;        // load the output register
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic sq_escape;   // squares of the stored z add up to more than 4.0
      logic at_max;      // completed passes reach the iteration limit
      logic box_escape;  // a part of the new z lies beyond +/-2.0
      logic out_free;    // the output register can take a result
   } status_type;

endpackage

### hdl/mbrot_datapath.sv
// Datapath: configuration registers, c formation, iteration arithmetic and output register.
module mbrot_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  mbrot_pkg::cmd_type                cmd,
   output mbrot_pkg::status_type             status,
   input  logic                              csr_write,
   input  logic [mbrot_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [mbrot_pkg::COORD_W-1:0]     csr_data,
   input  logic [mbrot_pkg::REQ_DATA_W-1:0]  req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [mbrot_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic                              rsp_tuser
);
   import mbrot_pkg::*;

   localparam logic signed [N_W-1:0] BOX_HI     = N_W'(2) <<< FRAC_BITS;
   localparam logic signed [N_W-1:0] BOX_LO     = -BOX_HI;
   localparam logic signed [P_W:0]   ESC_LIMIT  = (P_W + 1)'(4) <<< FRAC_BITS;

   // Configuration registers.
   logic [COUNT_W-1:0]        max_ff;
   logic signed [COORD_W-1:0] origin_re_ff, origin_im_ff, step_re_ff, step_im_ff;

   // Pixel and constant c.
   logic [PIX_W-1:0]          col_ff, row_ff;
   logic signed [OFF_W-1:0]   off_re_ff, off_im_ff, off_re_in, off_im_in;
   logic signed [C_W-1:0]     cr_ff, ci_ff, cr_in, ci_in;

   // Iteration state.
   logic signed [Z_W-1:0]     zr_ff, zi_ff;
   logic signed [P_W-1:0]     sr_ff, si_ff, cross_ff, sr_in, si_in, cross_in;
   logic [COUNT_W-1:0]        count_ff, count_eff, res_count_ff, res_count_in;
   logic signed [2*Z_W-1:0]   prod_rr, prod_ii, prod_ri;
   logic signed [N_W-1:0]     nr, ni;
   logic signed [P_W:0]       sq_sum;

   // Output register.
   logic                      rsp_valid_ff;
   logic [RSP_DATA_W-1:0]     rsp_data_ff;
   logic                      rsp_inside_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff       <= RESET_MAX_ITER;
         origin_re_ff <= RESET_ORIGIN_RE;
         origin_im_ff <= RESET_ORIGIN_IM;
         step_re_ff   <= RESET_STEP_RE;
         step_im_ff   <= RESET_STEP_IM;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_MAX_ITER:  max_ff       <= csr_data[COUNT_W-1:0];
            REG_ORIGIN_RE: origin_re_ff <= $signed(csr_data);
            REG_ORIGIN_IM: origin_im_ff <= $signed(csr_data);
            REG_STEP_RE:   step_re_ff   <= $signed(csr_data);
            REG_STEP_IM:   step_im_ff   <= $signed(csr_data);
            default: ;
         endcase
      end
   end

   // c = origin + index * step, formed in two registered steps.
   always_comb begin
      off_re_in = $signed({1'b0, col_ff}) * step_re_ff;
      off_im_in = $signed({1'b0, row_ff}) * step_im_ff;
      cr_in     = C_W'(origin_re_ff) + C_W'(off_re_ff);
      ci_in     = C_W'(origin_im_ff) + C_W'(off_im_ff);
   end

   // Exact products, then a floor shift back to the fixed-point scale.
   // The cross term carries the factor two by shifting one place less.
   always_comb begin
      prod_rr  = zr_ff * zr_ff;
      prod_ii  = zi_ff * zi_ff;
      prod_ri  = zr_ff * zi_ff;
      sr_in    = $signed(prod_rr[FRAC_BITS +: P_W]);
      si_in    = $signed(prod_ii[FRAC_BITS +: P_W]);
      cross_in = $signed(prod_ri[FRAC_BITS-1 +: P_W]);
   end

   // Next z, the range box and the squared-magnitude test of the stored z.
   always_comb begin
      nr           = N_W'(sr_ff) - N_W'(si_ff) + N_W'(cr_ff);
      ni           = N_W'(cross_ff) + N_W'(ci_ff);
      sq_sum       = (P_W + 1)'(sr_ff) + (P_W + 1)'(si_ff);
      count_eff    = cmd.first ? count_ff : count_ff + COUNT_W'(1);
      res_count_in = cmd.hold_count ? count_ff : count_eff;
   end

   assign status.sq_escape  = (sq_sum > ESC_LIMIT);
   assign status.at_max     = (count_eff == max_ff);
   assign status.box_escape = (nr > BOX_HI) || (nr < BOX_LO) || (ni > BOX_HI) || (ni < BOX_LO);
   assign status.out_free   = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         col_ff   <= req_tdata[PIX_W-1:0];
         row_ff   <= req_tdata[2*PIX_W-1:PIX_W];
         sr_ff    <= '0;
         si_ff    <= '0;
         cross_ff <= '0;
         count_ff <= '0;
      end
      if (cmd.mul_c) begin
         off_re_ff <= off_re_in;
         off_im_ff <= off_im_in;
      end
      if (cmd.add_c) begin
         cr_ff <= cr_in;
         ci_ff <= ci_in;
      end
      if (cmd.update) begin
         zr_ff        <= nr[Z_W-1:0];
         zi_ff        <= ni[Z_W-1:0];
         count_ff     <= count_eff;
         res_count_ff <= res_count_in;
      end
      if (cmd.square) begin
         sr_ff    <= sr_in;
         si_ff    <= si_in;
         cross_ff <= cross_in;
      end
      if (cmd.emit) begin
         rsp_data_ff   <= res_count_ff;
         rsp_inside_ff <= (res_count_ff == max_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_inside_ff;

endmodule

### hdl/mbrot_ctrl.sv
// Controller: sequences setup, the update/square iteration loop and result hand-off.
module mbrot_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  mbrot_pkg::status_type status,
   output mbrot_pkg::cmd_type    cmd
);
   import mbrot_pkg::*;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_MULC   = 3'd1;
   localparam logic [2:0] ST_ADDC   = 3'd2;
   localparam logic [2:0] ST_UPDATE = 3'd3;
   localparam logic [2:0] ST_SQUARE = 3'd4;
   localparam logic [2:0] ST_FINISH = 3'd5;

   logic [2:0] state_ff, state_in;
   logic       first_ff, first_in;
   logic       hold;

   always_comb begin
      state_in   = state_ff;
      first_in   = first_ff;
      cmd        = '0;
      req_tready = 1'b0;
      hold       = !first_ff && status.sq_escape;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = ST_MULC;
            end
         end
         ST_MULC: begin
            cmd.mul_c = 1'b1;
            state_in  = ST_ADDC;
         end
         ST_ADDC: begin
            cmd.add_c = 1'b1;
            first_in  = 1'b1;
            state_in  = ST_UPDATE;
         end
         ST_UPDATE: begin
            cmd.update     = 1'b1;
            cmd.first      = first_ff;
            cmd.hold_count = hold;
            if (hold || status.at_max || status.box_escape) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            cmd.square = 1'b1;
            first_in   = 1'b0;
            state_in   = ST_UPDATE;
         end
         ST_FINISH: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         first_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         first_ff <= first_in;
      end
   end

endmodule

### hdl/mandelbrot_escape_iteration.sv
// Top level of the escape-time block: ports, configuration handshake and unit wiring.
//
// Each transfer on the req_ channel names one pixel by column and row. The block
// forms c = origin + column * step_real + i * (origin_imag + row * step_imag)
// in signed fixed point and iterates z = z * z + c from zero. One transfer on
// the rsp_ channel returns the number of passes completed before |z| left the
// radius-two disk, and a flag that is set when the iteration limit was reached.
// Pixels are worked one at a time; req_tready is high only while no pixel is in work.
// Each pass is one update step and one squaring step on the three 31x31 multipliers,
// so that loop sets the rate. Setup of c takes a multiply step and an add step, and
// the controller can take the next pixel in the cycle after the result is loaded.
// The result waits in an output register, so a stalled receiver does not stop the
// next pixel from being taken and iterated; only the next result waits for the
// register to drain. The csr_ port is always ready and is to be written by the user
// only while the block is idle; the block itself does not enforce this. Reset is
// synchronous: it empties the output register, returns the controller to idle and
// loads every configuration register with its default.
module mandelbrot_escape_iteration (
   input  logic                              clock,
   input  logic                              reset,
   // Input stream. tdata: pixel_col [8:0], pixel_row [17:9], zeros [23:18].
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [mbrot_pkg::REQ_DATA_W-1:0]  req_tdata,
   // Result stream. tdata: iteration_count [15:0]. tuser: inside_set [0].
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [mbrot_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic                              rsp_tuser,
   // Configuration writes.
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [mbrot_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [mbrot_pkg::COORD_W-1:0]     csr_data
);
   import mbrot_pkg::*;

   cmd_type    cmd;
   status_type status;
   logic       csr_write;

   // Registers take a write in any cycle; writes to unused indexes are dropped.
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   mbrot_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   mbrot_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .csr_write  (csr_write),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

### tb/tb_top.sv
// Self-checking testbench for the Mandelbrot escape-time block.
module tb_top;
   import mbrot_pkg::*;

   localparam int     RESET_CYCLES  = 12;
   localparam int     MAX_IDLE      = 17;
   localparam int     SETTLE_CYCLES = 12;
   localparam int     LONG_HOLD     = 1500;
   localparam int     RANDOM_PHASES = 14;
   localparam int     REG_COUNT     = 5;
   localparam int     SPARE_LAST    = (1 << CSR_INDEX_W) - 1;
   localparam longint FIX_ONE       = longint'(1) << FRAC_BITS;

   // One pixel result as the block reports it.
   typedef struct packed {
      logic [COUNT_W-1:0] count;
      logic               in_set;
   } escape_result_type;

   logic                   clock;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   rsp_tuser;
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [COORD_W-1:0]     csr_data   = '0;

   // Our own copy of the configuration, updated on every accepted register write.
   logic [COUNT_W-1:0] cfg_max_iter  = RESET_MAX_ITER;
   longint             cfg_origin_re = RESET_ORIGIN_RE;
   longint             cfg_origin_im = RESET_ORIGIN_IM;
   longint             cfg_step_re   = RESET_STEP_RE;
   longint             cfg_step_im   = RESET_STEP_IM;

   // Pixels waiting to be offered, packed as {row, col}, and results still owed by the block.
   logic [2*PIX_W-1:0] pixel_queue[$];
   escape_result_type  awaited_escapes[$];

   bit          idle_off       = 1'b0;
   bit          long_hold_arm  = 1'b0;
   bit          long_hold_done = 1'b0;
   int unsigned send_gap       = 0;
   int unsigned rsp_wait       = 0;
   int unsigned hold_left      = 0;
   int unsigned fault_count    = 0;
   int unsigned results_seen   = 0;
   int unsigned inside_seen    = 0;
   int unsigned pixels_sent    = 0;
   int unsigned pixels_taken   = 0;
   int unsigned settings_used  = 0;
   int unsigned reg_writes     = 0;
   longint      cycle_count    = 0;
   longint      cycle_limit    = 4 * (RESET_CYCLES + LONG_HOLD) + 20000;

   mandelbrot_escape_iteration i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Exact product of two fixed-point values, scaled back with rounding toward minus infinity.
   function automatic longint fix_mul(longint a, longint b);
      logic signed [127:0] prod;
      prod = $signed({{64{a[63]}}, a}) * $signed({{64{b[63]}}, b});
      return prod[FRAC_BITS +: 64];
   endfunction

   // Escape time of one pixel under the current configuration.
   // A part of z beyond +/-2.0 escapes at once; otherwise |z|^2 > 4.0 is tested on the
   // scaled squares, so a point sitting exactly on the radius-two circle keeps counting.
   function automatic escape_result_type escape_time(logic [PIX_W-1:0] col,
                                                     logic [PIX_W-1:0] row);
      longint            cr, ci, zr, zi, sq_re, sq_im, cross_term;
      int unsigned       passes;
      escape_result_type res;
      cr     = cfg_origin_re + longint'(col) * cfg_step_re;
      ci     = cfg_origin_im + longint'(row) * cfg_step_im;
      zr     = 0;
      zi     = 0;
      passes = 0;
      while (passes < cfg_max_iter) begin
         sq_re      = fix_mul(zr, zr);
         sq_im      = fix_mul(zi, zi);
         cross_term = fix_mul(zr * 2, zi);
         zr         = sq_re - sq_im + cr;
         zi         = cross_term + ci;
         if (zr > 2 * FIX_ONE || zr < -2 * FIX_ONE || zi > 2 * FIX_ONE || zi < -2 * FIX_ONE)
            break;
         sq_re = fix_mul(zr, zr);
         sq_im = fix_mul(zi, zi);
         if (sq_re > 4 * FIX_ONE - sq_im)
            break;
         passes++;
      end
      res.count  = passes[COUNT_W-1:0];
      res.in_set = (passes == cfg_max_iter);
      return res;
   endfunction

   // Wait before the next transfer on either side; some phases run with no gaps at all.
   function automatic int unsigned idle_draw();
      if (idle_off || $urandom_range(0, 3) == 0)
         return 0;
      return $urandom_range(0, MAX_IDLE);
   endfunction

   task automatic note_fault(string what, longint unsigned want, longint unsigned got);
      fault_count++;
      if (fault_count <= 10)
         $display("tb_top: mismatch on %s at result %0d: expected %0d, got %0d",
                  what, results_seen, want, got);
   endtask

   // Pixel driver. A pixel stays offered until its transfer; then the drawn gap runs out
   // before the next one is offered. The expectation is formed at the accepting edge.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         send_gap   <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            awaited_escapes.push_back(escape_time(req_tdata[PIX_W-1:0],
                                                  req_tdata[2*PIX_W-1:PIX_W]));
            pixels_taken++;
         end
         if (!req_tvalid || req_tready) begin
            if (send_gap != 0) begin
               send_gap   <= send_gap - 1;
               req_tvalid <= 1'b0;
            end else if (pixel_queue.size() != 0) begin
               req_tdata  <= {{(REQ_DATA_W - 2 * PIX_W){1'b0}}, pixel_queue.pop_front()};
               req_tvalid <= 1'b1;
               send_gap   <= idle_draw();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Receiver ready. After each result transfer it waits a drawn number of cycles; once in
   // the run it holds off for a long stretch so the block fills and stalls its input.
   always @(posedge clock) begin : rsp_ready_gen
      int unsigned next_wait;
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_wait   <= 0;
         hold_left  <= 0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= (hold_left == 1);
      end else if (long_hold_arm && !long_hold_done) begin
         hold_left      <= LONG_HOLD;
         long_hold_done <= 1'b1;
         rsp_tready     <= 1'b0;
      end else if (rsp_tvalid && rsp_tready) begin
         next_wait = idle_draw();
         rsp_wait   <= next_wait;
         rsp_tready <= (next_wait == 0);
      end else if (rsp_wait != 0) begin
         rsp_wait   <= rsp_wait - 1;
         rsp_tready <= (rsp_wait == 1);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Result monitor: every result transfer is matched against the oldest expectation.
   always @(posedge clock) begin : result_check
      escape_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (awaited_escapes.size() == 0) begin
            note_fault("unexpected result", 0, rsp_tdata);
         end else begin
            want = awaited_escapes.pop_front();
            if (rsp_tdata !== want.count)
               note_fault("iteration_count", want.count, rsp_tdata);
            if (rsp_tuser !== want.in_set)
               note_fault("inside_set", want.in_set, rsp_tuser);
            if (want.in_set)
               inside_seen++;
         end
         results_seen++;
      end
   end

   // Watchdog. The limit grows with every pixel queued, sized from its worst-case latency
   // plus both sides' longest gaps, and is taken four times over.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > cycle_limit) begin
         $display("tb_top: timeout after %0d cycles", cycle_count);
         $display("tb_top: done, errors");
         $finish;
      end
   end

   task automatic push_pixel(logic [PIX_W-1:0] col, logic [PIX_W-1:0] row);
      pixel_queue.push_back({row, col});
      pixels_sent++;
      cycle_limit += 4 * (2 * longint'(cfg_max_iter) + 5 + 2 * MAX_IDLE + 8);
   endtask

   // Wait at falling edges until nothing is queued, offered or owed, then let the
   // block settle. Returns just after a rising edge.
   task automatic drain(int unsigned settle);
      @(negedge clock);
      while (pixel_queue.size() != 0 || req_tvalid || awaited_escapes.size() != 0)
         @(negedge clock);
      repeat (settle) @(posedge clock);
   endtask

   // One register write; called just after a rising edge with csr_valid free to stay high.
   task automatic write_reg(logic [CSR_INDEX_W-1:0] idx, logic [COORD_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         REG_MAX_ITER:  cfg_max_iter  = value[COUNT_W-1:0];
         REG_ORIGIN_RE: cfg_origin_re = $signed(value);
         REG_ORIGIN_IM: cfg_origin_im = $signed(value);
         REG_STEP_RE:   cfg_step_re   = $signed(value);
         REG_STEP_IM:   cfg_step_im   = $signed(value);
         default: ;
      endcase
      reg_writes++;
   endtask

   // Writes a whole setting. The limit goes out with random upper bits, which the block
   // must drop. A write to an unused index may be added; it must change nothing.
   task automatic apply_setting(logic [COUNT_W-1:0] lim, logic [COORD_W-1:0] ore,
                                logic [COORD_W-1:0] oim, logic [COORD_W-1:0] sre,
                                logic [COORD_W-1:0] sim, bit with_spare);
      write_reg(REG_MAX_ITER, {16'($urandom), lim});
      if (with_spare)
         write_reg(CSR_INDEX_W'($urandom_range(REG_COUNT, SPARE_LAST)), $urandom);
      write_reg(REG_ORIGIN_RE, ore);
      write_reg(REG_ORIGIN_IM, oim);
      write_reg(REG_STEP_RE, sre);
      write_reg(REG_STEP_IM, sim);
      csr_valid <= 1'b0;
      settings_used++;
      cycle_limit += 4 * (SETTLE_CYCLES + 16);
      @(negedge clock);
   endtask

   initial begin : stimulus
      int unsigned        n;
      logic [COUNT_W-1:0] lim;
      logic [COORD_W-1:0] ore, oim, sre, sim;
      int unsigned        settle;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset values: corners of the frame, an inside point near the origin and one
      // that escapes after a few passes.
      settings_used = 1;
      push_pixel(0, 0);
      push_pixel(511, 511);
      push_pixel(511, 0);
      push_pixel(0, 511);
      push_pixel(341, 170);
      push_pixel(170, 85);

      // Largest limit with c = 0, which never escapes; the extreme steps throw every
      // other pixel far outside the box on the first pass.
      drain(SETTLE_CYCLES);
      apply_setting(16'hFFFF, '0, '0, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
      push_pixel(0, 0);
      push_pixel(1, 0);
      push_pixel(0, 1);
      push_pixel(511, 511);

      // Limit of zero: no pass is made, so every pixel reports zero and inside.
      drain(SETTLE_CYCLES);
      apply_setting('0, 32'h8000_0000, 32'h7FFF_FFFF, '0, '0, 1'b1);
      push_pixel(5, 9);
      push_pixel(511, 0);
      push_pixel(0, 511);

      // Quarter-unit grid from -2: c = -2 and c = 0.25 lie on the border yet inside,
      // c = 2 and c = 2i touch the circle once before escaping, c = i is periodic.
      drain(SETTLE_CYCLES);
      apply_setting(16'd50, 32'(-2 * FIX_ONE), '0, 32'(FIX_ONE / 4), 32'(FIX_ONE / 4), 1'b0);
      push_pixel(0, 0);
      push_pixel(9, 0);
      push_pixel(8, 0);
      push_pixel(10, 0);
      push_pixel(16, 0);
      push_pixel(8, 8);
      push_pixel(0, 8);
      push_pixel(8, 4);
      push_pixel(17, 0);

      // Random phases. Most frame a window around the set with small limits so pixels
      // take every path through the loop; the rest use raw register values.
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         drain(SETTLE_CYCLES);
         case ($urandom_range(0, 9))
            0:       lim = 1;
            1, 2:    lim = $urandom_range(100, 400);
            default: lim = $urandom_range(2, 48);
         endcase
         if ($urandom_range(0, 3) != 0) begin
            ore = 32'(longint'($urandom_range(0, 3 * FIX_ONE)) - 5 * FIX_ONE / 2);
            oim = 32'(longint'($urandom_range(0, 3 * FIX_ONE)) - 3 * FIX_ONE / 2);
            sre = 32'(longint'($urandom_range(0, 7 * FIX_ONE / 1024)));
            sim = 32'(longint'($urandom_range(0, 7 * FIX_ONE / 1024)));
            if ($urandom_range(0, 1) == 1)
               sre = -sre;
            if ($urandom_range(0, 1) == 1)
               sim = -sim;
         end else begin
            ore = $urandom;
            oim = $urandom;
            sre = $urandom;
            sim = $urandom;
         end
         apply_setting(lim, ore, oim, sre, sim, ($urandom_range(0, 2) == 0));
         idle_off = ($urandom_range(0, 4) == 0);
         if (p == 2)
            long_hold_arm = 1'b1;
         n = $urandom_range(30, 54);
         repeat (n) push_pixel(9'($urandom), 9'($urandom));
      end

      // Allow one more worst-case pixel time after the last result, within a cap.
      settle = 2 * cfg_max_iter + 10;
      if (settle > 4000)
         settle = 4000;
      cycle_limit += 4 * settle;
      drain(settle);

      if (awaited_escapes.size() != 0) begin
         $display("tb_top: %0d results never arrived", awaited_escapes.size());
         fault_count += awaited_escapes.size();
      end
      $display("tb_top: %0d pixels over %0d register settings (%0d writes), %0d results",
               pixels_taken, settings_used, reg_writes, results_seen);
      $display("tb_top: %0d inside the set, %0d faults, %0d cycles",
               inside_seen, fault_count, cycle_count);
      if (fault_count == 0)
         $display("tb_top: done, clean");
      else
         $display("tb_top: done, errors");
      $finish;
   end

endmodule
